// ===== src/i2cedid_pkg.sv =====
`timescale 1ns / 1ps

package i2cedid_pkg;

    localparam int BLOCK_BYTES = 128;
    localparam int BYTE_IDX_W  = $clog2(BLOCK_BYTES);
    localparam int TMR_W       = 16;
    localparam int CFG_IDX_W   = 8;

    localparam logic [BYTE_IDX_W-1:0] LAST_BYTE_IDX = BYTE_IDX_W'(BLOCK_BYTES - 1);
    localparam logic [3:0]            BIT_ACK       = 4'd8;
    localparam logic [7:0]            ADDR_WR       = 8'hA0;
    localparam logic [7:0]            ADDR_RD       = 8'hA1;
    localparam logic [TMR_W-1:0]      TMR_MAX       = {TMR_W{1'b1}};
    localparam logic [TMR_W-1:0]      HALF_PERIOD_RST   = 16'd10;
    localparam logic [TMR_W-1:0]      STRETCH_LIMIT_RST = 16'd100;

    localparam logic [CFG_IDX_W-1:0] CFG_HALF_PERIOD   = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_STRETCH_LIMIT = 8'd1;

    localparam logic FUNC_TICK  = 1'b0;
    localparam logic FUNC_BEGIN = 1'b1;

    typedef enum logic [3:0] {
        PH_IDLE,
        PH_START_WAIT,
        PH_START_A,
        PH_START_B,
        PH_START_C,
        PH_BIT_SETUP,
        PH_BIT_WAIT,
        PH_BIT_HOLD,
        PH_STOP_A,
        PH_STOP_WAIT,
        PH_STOP_B,
        PH_STOP_C
    } phase_t;

    typedef enum logic [1:0] {
        STG_ADDR_WR,
        STG_OFFSET,
        STG_ADDR_RD,
        STG_DATA
    } stage_t;

    typedef struct packed {
        logic [TMR_W-1:0] half_period_ticks;
        logic [TMR_W-1:0] stretch_limit;
    } cfg_t;

    typedef struct packed {
        logic       func;
        logic [7:0] block_number;
        logic       scl_level;
        logic       sda_level;
    } item_t;

    typedef struct packed {
        logic                  scl_release;
        logic                  sda_release;
        logic                  busy_res;
        logic                  byte_valid;
        logic [7:0]            byte_value;
        logic [BYTE_IDX_W-1:0] byte_index;
        logic                  last_byte;
        logic                  done_res;
        logic                  success;
        logic                  bus_stuck;
    } res_t;

endpackage

// ===== src/i2c_edid_block_reader.sv =====
`timescale 1ns / 1ps

// Open-drain I2C master that reads one 128-byte EDID block, one input transfer per tick or
// begin command, with exactly one result transfer for each input transfer. The block takes
// one input transfer every clock cycle when the result side keeps up. Each result is
// registered: the state machine works on the item held in the input register and, once
// the result register is free to take it, updates the bus state and loads the result
// register. Configuration writes are accepted at any time and apply at once, so they belong
// to periods when no input transfer is waiting in the block.
module i2c_edid_block_reader
    import i2cedid_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,

    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic                  s_func,
    input  logic [7:0]            s_block_number,
    input  logic                  s_scl_level,
    input  logic                  s_sda_level,

    output logic                  m_valid,
    input  logic                  m_ready,
    output logic                  m_scl_release,
    output logic                  m_sda_release,
    output logic                  m_busy_res,
    output logic                  m_byte_valid,
    output logic [7:0]            m_byte_value,
    output logic [BYTE_IDX_W-1:0] m_byte_index,
    output logic                  m_last_byte,
    output logic                  m_done_res,
    output logic                  m_success,
    output logic                  m_bus_stuck,

    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [TMR_W-1:0]      cfg_data
);

    logic  in_vld_reg, in_vld_next;
    item_t item_reg, item_next;
    logic  out_vld_reg, out_vld_next;
    res_t  res_reg, res_next;
    res_t  res;
    cfg_t  cfg;
    logic  adv;
    logic  s_fire;

    assign cfg_ready = 1'b1;
    assign adv       = in_vld_reg && (!out_vld_reg || m_ready);
    assign s_ready   = !in_vld_reg || adv;
    assign s_fire    = s_valid && s_ready;

    i2cedid_cfg u_cfg (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_en    (cfg_valid && cfg_ready),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .cfg      (cfg)
    );

    i2cedid_fsm u_fsm (
        .aclk    (aclk),
        .aresetn (aresetn),
        .adv     (adv),
        .item    (item_reg),
        .cfg     (cfg),
        .res     (res)
    );

    always_comb begin
        in_vld_next = in_vld_reg;
        item_next   = item_reg;
        if (s_fire) begin
            in_vld_next            = 1'b1;
            item_next.func         = s_func;
            item_next.block_number = s_block_number;
            item_next.scl_level    = s_scl_level;
            item_next.sda_level    = s_sda_level;
        end else if (adv) begin
            in_vld_next = 1'b0;
        end

        out_vld_next = out_vld_reg;
        res_next     = res_reg;
        if (adv) begin
            out_vld_next = 1'b1;
            res_next     = res;
        end else if (m_ready) begin
            out_vld_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end else begin
            in_vld_reg  <= in_vld_next;
            out_vld_reg <= out_vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        item_reg <= item_next;
        res_reg  <= res_next;
    end

    assign m_valid       = out_vld_reg;
    assign m_scl_release = res_reg.scl_release;
    assign m_sda_release = res_reg.sda_release;
    assign m_busy_res    = res_reg.busy_res;
    assign m_byte_valid  = res_reg.byte_valid;
    assign m_byte_value  = res_reg.byte_value;
    assign m_byte_index  = res_reg.byte_index;
    assign m_last_byte   = res_reg.last_byte;
    assign m_done_res    = res_reg.done_res;
    assign m_success     = res_reg.success;
    assign m_bus_stuck   = res_reg.bus_stuck;

    a_done_not_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_done_res |-> !m_busy_res && !m_byte_valid)
        else $error("done result reported while a read is still in progress");

    a_last_byte_index: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_last_byte |-> m_byte_valid && (m_byte_index == LAST_BYTE_IDX))
        else $error("last byte flag on a byte that is not the final one");

    a_item_kept: assert property (@(posedge aclk) disable iff (!aresetn)
        in_vld_reg && !adv |=> in_vld_reg && $stable(item_reg))
        else $error("stalled input item was lost or changed");

    a_result_follows: assert property (@(posedge aclk) disable iff (!aresetn)
        adv |=> m_valid)
        else $error("processed item produced no result transfer");

endmodule

// ===== src/i2cedid_cfg.sv =====
`timescale 1ns / 1ps

module i2cedid_cfg
    import i2cedid_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 wr_en,
    input  logic [CFG_IDX_W-1:0] wr_index,
    input  logic [TMR_W-1:0]     wr_data,
    output cfg_t                 cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb begin
        cfg_next = cfg_reg;
        if (wr_en) begin
            unique case (wr_index)
                CFG_HALF_PERIOD:   cfg_next.half_period_ticks = wr_data;
                CFG_STRETCH_LIMIT: cfg_next.stretch_limit     = wr_data;
                default:           cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.half_period_ticks <= HALF_PERIOD_RST;
            cfg_reg.stretch_limit     <= STRETCH_LIMIT_RST;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// ===== src/i2cedid_fsm.sv =====
`timescale 1ns / 1ps

module i2cedid_fsm
    import i2cedid_pkg::*;
(
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  adv,
    input  item_t item,
    input  cfg_t  cfg,
    output res_t  res
);

    phase_t                phase_reg, phase_next;
    stage_t                stage_reg, stage_next;
    logic [3:0]            bit_cnt_reg, bit_cnt_next;
    logic [BYTE_IDX_W-1:0] byte_cnt_reg, byte_cnt_next;
    logic [7:0]            shift_reg, shift_next;
    logic [TMR_W-1:0]      half_tmr_reg, half_tmr_next;
    logic [TMR_W-1:0]      stretch_tmr_reg, stretch_tmr_next;
    logic                  offset_bit_reg, offset_bit_next;
    logic                  stuck_reg, stuck_next;
    logic                  ok_reg, ok_next;
    logic                  scl_rel_reg, scl_rel_next;
    logic                  sda_rel_reg, sda_rel_next;

    logic [TMR_W-1:0] half_inc;
    logic [TMR_W-1:0] stretch_inc;
    logic             half_done;
    logic             stretch_timeout;
    logic             scl_up;
    logic             is_tick;
    logic             bit_is_ack;
    logic             last_data;
    logic             samples;
    logic [3:0]       bit_inc;
    logic [7:0]       shift_held;

    assign is_tick         = (item.func == FUNC_TICK);
    assign half_inc        = (half_tmr_reg == TMR_MAX) ? half_tmr_reg : half_tmr_reg + 1'b1;
    assign half_done       = (half_inc >= cfg.half_period_ticks);
    assign stretch_inc     = (stretch_tmr_reg == TMR_MAX) ? stretch_tmr_reg
                                                          : stretch_tmr_reg + 1'b1;
    assign stretch_timeout = !item.scl_level && (stretch_inc >= cfg.stretch_limit);
    assign scl_up          = item.scl_level || stretch_timeout;
    assign bit_is_ack      = (bit_cnt_reg == BIT_ACK);
    assign last_data       = (byte_cnt_reg == LAST_BYTE_IDX);
    assign samples         = (stage_reg == STG_DATA) ? !bit_is_ack : bit_is_ack;
    assign bit_inc         = bit_cnt_reg + 1'b1;
    assign shift_held      = (stage_reg != STG_DATA && !bit_is_ack) ? {shift_reg[6:0], 1'b0}
                                                                    : shift_reg;

    always_comb begin
        phase_next = phase_reg;
        if (!is_tick) begin
            if (phase_reg == PH_IDLE) begin
                phase_next = PH_START_WAIT;
            end
        end else begin
            unique case (phase_reg)
                PH_IDLE:       phase_next = PH_IDLE;
                PH_START_WAIT: if (scl_up) phase_next = PH_START_A;
                PH_START_A:    if (half_done) phase_next = PH_START_B;
                PH_START_B:    if (half_done) phase_next = PH_START_C;
                PH_START_C:    if (half_done) phase_next = PH_BIT_SETUP;
                PH_BIT_SETUP:  if (half_done) phase_next = PH_BIT_WAIT;
                PH_BIT_WAIT:   if (scl_up) phase_next = PH_BIT_HOLD;
                PH_BIT_HOLD: begin
                    if (half_done) begin
                        if (!bit_is_ack) begin
                            phase_next = PH_BIT_SETUP;
                        end else if (stage_reg != STG_DATA) begin
                            if (shift_reg[0]) begin
                                phase_next = PH_STOP_A;
                            end else if (stage_reg == STG_OFFSET) begin
                                phase_next = PH_START_WAIT;
                            end else begin
                                phase_next = PH_BIT_SETUP;
                            end
                        end else begin
                            phase_next = last_data ? PH_STOP_A : PH_BIT_SETUP;
                        end
                    end
                end
                PH_STOP_A:     if (half_done) phase_next = PH_STOP_WAIT;
                PH_STOP_WAIT:  if (scl_up) phase_next = PH_STOP_B;
                PH_STOP_B:     if (half_done) phase_next = PH_STOP_C;
                PH_STOP_C:     if (half_done) phase_next = PH_IDLE;
                default:       phase_next = PH_IDLE;
            endcase
        end
    end

    always_comb begin
        stage_next       = stage_reg;
        bit_cnt_next     = bit_cnt_reg;
        byte_cnt_next    = byte_cnt_reg;
        shift_next       = shift_reg;
        half_tmr_next    = half_tmr_reg;
        stretch_tmr_next = stretch_tmr_reg;
        offset_bit_next  = offset_bit_reg;
        stuck_next       = stuck_reg;
        ok_next          = ok_reg;
        scl_rel_next     = scl_rel_reg;
        sda_rel_next     = sda_rel_reg;
        res              = '0;

        if (!is_tick) begin
            if (phase_reg == PH_IDLE) begin
                offset_bit_next  = item.block_number[0];
                stuck_next       = 1'b0;
                ok_next          = 1'b1;
                stage_next       = STG_ADDR_WR;
                byte_cnt_next    = '0;
                bit_cnt_next     = '0;
                sda_rel_next     = 1'b1;
                scl_rel_next     = 1'b1;
                stretch_tmr_next = '0;
            end
        end else begin
            case (phase_reg)
                PH_START_WAIT, PH_BIT_WAIT, PH_STOP_WAIT: begin
                    if (!item.scl_level) begin
                        stretch_tmr_next = stretch_inc;
                    end
                    if (stretch_timeout) begin
                        stuck_next = 1'b1;
                    end
                    if (scl_up) begin
                        half_tmr_next = '0;
                        if (phase_reg == PH_BIT_WAIT && samples) begin
                            shift_next = {shift_reg[6:0], item.sda_level};
                        end
                    end
                end
                PH_START_A, PH_START_B, PH_START_C, PH_BIT_SETUP, PH_BIT_HOLD,
                PH_STOP_A, PH_STOP_B, PH_STOP_C: begin
                    half_tmr_next = half_done ? '0 : half_inc;
                    if (half_done) begin
                        case (phase_reg)
                            PH_START_A: sda_rel_next = 1'b0;
                            PH_START_B: scl_rel_next = 1'b0;
                            PH_START_C: begin
                                bit_cnt_next = '0;
                                shift_next   = (stage_reg == STG_ADDR_RD) ? ADDR_RD : ADDR_WR;
                                sda_rel_next = 1'b1;
                            end
                            PH_BIT_SETUP, PH_STOP_A: begin
                                scl_rel_next     = 1'b1;
                                stretch_tmr_next = '0;
                            end
                            PH_BIT_HOLD: begin
                                scl_rel_next = 1'b0;
                                shift_next   = shift_held;
                                if (!bit_is_ack) begin
                                    bit_cnt_next = bit_inc;
                                    if (stage_reg != STG_DATA && bit_inc != BIT_ACK) begin
                                        sda_rel_next = shift_held[7];
                                    end else if (stage_reg == STG_DATA && bit_inc == BIT_ACK) begin
                                        sda_rel_next = last_data;
                                    end else begin
                                        sda_rel_next = 1'b1;
                                    end
                                end else if (stage_reg != STG_DATA) begin
                                    if (shift_reg[0]) begin
                                        ok_next      = 1'b0;
                                        sda_rel_next = 1'b0;
                                    end else if (stage_reg == STG_ADDR_WR) begin
                                        stage_next   = STG_OFFSET;
                                        shift_next   = {offset_bit_reg, 7'd0};
                                        bit_cnt_next = '0;
                                        sda_rel_next = offset_bit_reg;
                                    end else if (stage_reg == STG_OFFSET) begin
                                        stage_next       = STG_ADDR_RD;
                                        sda_rel_next     = 1'b1;
                                        scl_rel_next     = 1'b1;
                                        stretch_tmr_next = '0;
                                    end else begin
                                        stage_next    = STG_DATA;
                                        byte_cnt_next = '0;
                                        shift_next    = '0;
                                        bit_cnt_next  = '0;
                                        sda_rel_next  = 1'b1;
                                    end
                                end else begin
                                    res.byte_valid = 1'b1;
                                    res.byte_value = shift_reg;
                                    res.byte_index = byte_cnt_reg;
                                    res.last_byte  = last_data;
                                    if (last_data) begin
                                        sda_rel_next = 1'b0;
                                    end else begin
                                        byte_cnt_next = byte_cnt_reg + 1'b1;
                                        shift_next    = '0;
                                        bit_cnt_next  = '0;
                                        sda_rel_next  = 1'b1;
                                    end
                                end
                            end
                            PH_STOP_B: sda_rel_next = 1'b1;
                            PH_STOP_C: begin
                                scl_rel_next = 1'b1;
                                sda_rel_next = 1'b1;
                                res.done_res  = 1'b1;
                                res.success   = ok_reg && !stuck_reg;
                                res.bus_stuck = stuck_reg;
                            end
                            default: begin
                            end
                        endcase
                    end
                end
                default: begin
                end
            endcase
        end

        res.scl_release = scl_rel_next;
        res.sda_release = sda_rel_next;
        res.busy_res    = (phase_next != PH_IDLE);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg       <= PH_IDLE;
            stage_reg       <= STG_ADDR_WR;
            bit_cnt_reg     <= '0;
            byte_cnt_reg    <= '0;
            shift_reg       <= '0;
            half_tmr_reg    <= '0;
            stretch_tmr_reg <= '0;
            offset_bit_reg  <= 1'b0;
            stuck_reg       <= 1'b0;
            ok_reg          <= 1'b0;
            scl_rel_reg     <= 1'b1;
            sda_rel_reg     <= 1'b1;
        end else if (adv) begin
            phase_reg       <= phase_next;
            stage_reg       <= stage_next;
            bit_cnt_reg     <= bit_cnt_next;
            byte_cnt_reg    <= byte_cnt_next;
            shift_reg       <= shift_next;
            half_tmr_reg    <= half_tmr_next;
            stretch_tmr_reg <= stretch_tmr_next;
            offset_bit_reg  <= offset_bit_next;
            stuck_reg       <= stuck_next;
            ok_reg          <= ok_next;
            scl_rel_reg     <= scl_rel_next;
            sda_rel_reg     <= sda_rel_next;
        end
    end

endmodule
